// ----- rtl/dlbg_pkg.sv -----
// Shared types, codes and fixed-point helpers for the dense layer gradient engine.
`default_nettype none
package dlbg_pkg;

  localparam int FUNC_W   = 3;
  localparam int INDEX_W  = 10;
  localparam int VAL_W    = 16;
  localparam int KIND_W   = 2;
  localparam int CNT_W    = 6;
  localparam int NODE_W   = 9;
  localparam int LR_W     = 13;
  localparam int CFG_IDX_W = 2;
  localparam int WDEPTH   = 1024;
  localparam int ACC_W    = 32;

  localparam int MAX_INPUTS_DEF = 32;
  localparam int MAX_NODES_DEF  = 32;

  localparam logic [CNT_W-1:0] NUM_INPUTS_RST = 6'd32;
  localparam logic [CNT_W-1:0] NUM_NODES_RST  = 6'd32;
  localparam logic [LR_W-1:0]  LR_RST         = 13'd410;

  typedef enum logic [FUNC_W-1:0] {
    FN_WR_WEIGHT  = 3'd0,
    FN_WR_INPUT   = 3'd1,
    FN_NODE_STEP  = 3'd2,
    FN_RD_COSTS   = 3'd3,
    FN_UPD_WEIGHT = 3'd4
  } func_t;

  typedef enum logic [KIND_W-1:0] {
    KIND_BIAS   = 2'd0,
    KIND_WEIGHT = 2'd1,
    KIND_INPUT  = 2'd2
  } kind_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_NUM_INPUTS = 2'd0,
    REG_NUM_NODES  = 2'd1,
    REG_LAST_LAYER = 2'd2,
    REG_LRATE      = 2'd3
  } reg_idx_t;

  // Round a Q.24 product to Q.12, half up.
  function automatic logic signed [20:0] rnd12(input logic signed [32:0] p);
    logic signed [32:0] q;
    q = (p + 33'sd2048) >>> 12;
    return q[20:0];
  endfunction

  function automatic logic signed [15:0] sat16(input logic signed [20:0] v);
    logic signed [15:0] r;
    if (v > 21'sd32767) r = 16'sh7fff;
    else if (v < -21'sd32768) r = 16'sh8000;
    else r = v[15:0];
    return r;
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [32:0] v);
    logic signed [31:0] r;
    if (v > 33'sh0_7fff_ffff) r = 32'sh7fff_ffff;
    else if (v < -33'sh0_8000_0000) r = 32'sh8000_0000;
    else r = v[31:0];
    return r;
  endfunction

endpackage
`default_nettype wire

// ----- rtl/dlbg_if.sv -----
// Valid/ready channel interfaces for the input items and the result items.
`default_nettype none
interface dlbg_in_if;
  logic                                valid;
  logic                                ready;
  logic [dlbg_pkg::FUNC_W-1:0]         func;
  logic [dlbg_pkg::INDEX_W-1:0]        index;
  logic signed [dlbg_pkg::VAL_W-1:0]   value;
  logic signed [dlbg_pkg::VAL_W-1:0]   target_or_cost;
  modport source(output valid, func, index, value, target_or_cost, input ready);
  modport sink(input valid, func, index, value, target_or_cost, output ready);
endinterface

interface dlbg_out_if;
  logic                                valid;
  logic                                ready;
  logic [dlbg_pkg::KIND_W-1:0]         kind;
  logic [dlbg_pkg::INDEX_W-1:0]        position;
  logic signed [dlbg_pkg::VAL_W-1:0]   cost;
  logic                                last;
  modport source(output valid, kind, position, cost, last, input ready);
  modport sink(input valid, kind, position, cost, last, output ready);
endinterface
`default_nettype wire

// ----- rtl/dlbg_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module dlbg_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

// ----- rtl/dense_layer_backprop_gradients.sv -----
// Top level of the dense layer gradient engine: sequencer, datapath and stores.
`default_nettype none
// Gradient engine for one fully connected layer with sigmoid-derivative costs,
// signed Q3.12 with half-up rounding and saturation. Weights sit in a 1024-entry
// RAM, the per-input cost accumulators in a MAX_INPUTS-entry RAM whose entries
// carry valid bits (an invalid entry reads as zero, so reset and a read-costs
// transaction clear them all at once, no clearing pass). Layer inputs sit in a
// small register file. Update weight reads the weight RAM and forms the rate
// product together, then writes back. A node step runs two multiply stages
// for the bias cost, then one weight per cycle through a three-stage read /
// multiply / accumulate pipe that runs off the weight and accumulator RAM read
// ports, and ends once it sees the pipe empty. The pipe freezes whenever the
// result register is full and not taken. A new item is accepted only once the
// previous one has issued all its results; the last result may still be
// waiting in the output register.
module dense_layer_backprop_gradients #(
  parameter int MAX_INPUTS = dlbg_pkg::MAX_INPUTS_DEF,
  parameter int MAX_NODES  = dlbg_pkg::MAX_NODES_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  dlbg_in_if.sink                              in_ch,
  dlbg_out_if.source                           out_ch,
  input  wire logic                            cfg_we,
  input  wire logic [dlbg_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [dlbg_pkg::LR_W-1:0]       cfg_data
);

  localparam int IW = (MAX_INPUTS > 1) ? $clog2(MAX_INPUTS) : 1;
  localparam int WAW = $clog2(dlbg_pkg::WDEPTH);
  localparam logic [dlbg_pkg::CNT_W-1:0]   NI_MAX = dlbg_pkg::CNT_W'(MAX_INPUTS);
  localparam logic [dlbg_pkg::NODE_W-1:0]  NN_MAX = dlbg_pkg::NODE_W'(MAX_NODES);
  localparam logic [dlbg_pkg::INDEX_W-1:0] NI_LIM = dlbg_pkg::INDEX_W'(MAX_INPUTS);

  typedef enum logic [2:0] {
    ST_IDLE, ST_MUL1, ST_MUL2, ST_BIAS, ST_RUN, ST_UPD1, ST_UPD2
  } state_t;

  // configuration
  logic [dlbg_pkg::CNT_W-1:0] num_inputs_r, num_nodes_r;
  logic                       llm_r;
  logic [dlbg_pkg::LR_W-1:0]  lr_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      num_inputs_r <= dlbg_pkg::NUM_INPUTS_RST;
      num_nodes_r  <= dlbg_pkg::NUM_NODES_RST;
      llm_r        <= 1'b1;
      lr_r         <= dlbg_pkg::LR_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        dlbg_pkg::REG_NUM_INPUTS: num_inputs_r <= cfg_data[dlbg_pkg::CNT_W-1:0];
        dlbg_pkg::REG_NUM_NODES:  num_nodes_r  <= cfg_data[dlbg_pkg::CNT_W-1:0];
        dlbg_pkg::REG_LAST_LAYER: llm_r        <= cfg_data[0];
        dlbg_pkg::REG_LRATE:      lr_r         <= cfg_data;
        default: ;
      endcase
    end
  end

  // clamped counts
  logic [dlbg_pkg::CNT_W-1:0]  n_eff;
  logic [dlbg_pkg::NODE_W-1:0] m_raw, m_eff;
  assign m_raw = dlbg_pkg::NODE_W'(num_nodes_r);
  assign n_eff = (num_inputs_r == '0) ? dlbg_pkg::CNT_W'(1) :
                 (num_inputs_r > NI_MAX) ? NI_MAX : num_inputs_r;
  assign m_eff = (m_raw == '0) ? dlbg_pkg::NODE_W'(1) :
                 (m_raw > NN_MAX) ? NN_MAX : m_raw;

  state_t state_r, state_nxt;

  // latched transaction
  logic [dlbg_pkg::INDEX_W-1:0]      idx_r;
  logic signed [dlbg_pkg::VAL_W-1:0] val_r, toc_r;
  logic                              rc_r, rc_nxt;

  // arithmetic registers
  logic signed [32:0]                p1_r, p2_r, pw_r, pi_r;
  logic signed [dlbg_pkg::VAL_W-1:0] bias_r;
  logic [WAW-1:0]                    base_r, waddr_r;

  // weight pipe: issue counter, stage B (RAM data), stage C (products)
  logic [dlbg_pkg::CNT_W-1:0] cnt_r, cnt_nxt;
  logic                       vb_r, vb_nxt, vc_r, vc_nxt;
  logic [IW-1:0]              i_b_r, i_c_r;
  logic                       last_b_r, last_c_r;
  logic [WAW-1:0]             wa_b_r, wa_c_r;
  logic signed [31:0]         acc_c_r;

  // result register
  logic                              out_valid_r, out_valid_nxt;
  logic [dlbg_pkg::KIND_W-1:0]       kind_r;
  logic [dlbg_pkg::INDEX_W-1:0]      pos_r;
  logic signed [dlbg_pkg::VAL_W-1:0] cost_r;
  logic                              last_r;

  logic [MAX_INPUTS-1:0]              acc_vld_r, acc_vld_nxt;
  logic signed [dlbg_pkg::VAL_W-1:0]  in_store [MAX_INPUTS];

  logic in_acc, adv, issue, run_done;
  assign in_ch.ready = (state_r == ST_IDLE);
  assign in_acc      = in_ch.valid && in_ch.ready;
  assign adv         = !out_valid_r || out_ch.ready;
  assign issue       = (state_r == ST_RUN) && adv && (cnt_r < n_eff);
  assign run_done    = (state_r == ST_RUN) && (cnt_r == n_eff) && !vb_r && !vc_r;

  // weight RAM
  logic                         w_we, w_re;
  logic [WAW-1:0]               w_waddr, w_raddr;
  logic [dlbg_pkg::VAL_W-1:0]   w_wdata, w_rdata;
  // accumulator RAM
  logic                         a_we;
  logic [IW-1:0]                a_waddr;
  logic [dlbg_pkg::ACC_W-1:0]   a_wdata, a_rdata;

  logic signed [16:0]                omv, dif;
  logic signed [dlbg_pkg::VAL_W-1:0] s_val, bias_val, wnew;
  logic signed [20:0]                upd_diff;

  assign omv      = 17'sd4096 - 17'(val_r);
  assign s_val    = dlbg_pkg::sat16(dlbg_pkg::rnd12(p1_r));
  assign dif      = llm_r ? (17'(val_r) - 17'(toc_r)) : 17'(toc_r);
  assign bias_val = dlbg_pkg::sat16(dlbg_pkg::rnd12(p2_r));
  assign upd_diff = 21'($signed(w_rdata)) - dlbg_pkg::rnd12(p1_r);
  assign wnew     = dlbg_pkg::sat16(upd_diff);

  always_comb begin
    w_we    = 1'b0;
    w_waddr = idx_r[WAW-1:0];
    w_wdata = wnew;
    if (in_acc && (in_ch.func == dlbg_pkg::FN_WR_WEIGHT)) begin
      w_we    = 1'b1;
      w_waddr = in_ch.index[WAW-1:0];
      w_wdata = in_ch.value;
    end else if (state_r == ST_UPD2) begin
      w_we = 1'b1;
    end
  end
  assign w_re    = issue || (state_r == ST_UPD1);
  assign w_raddr = (state_r == ST_UPD1) ? idx_r[WAW-1:0] : waddr_r;

  assign a_we    = (state_r == ST_RUN) && adv && vc_r && !rc_r;
  assign a_waddr = i_c_r;
  assign a_wdata = dlbg_pkg::sat32(33'(acc_c_r) + 33'(dlbg_pkg::rnd12(pw_r)));

  dlbg_ram #(.WIDTH(dlbg_pkg::VAL_W), .DEPTH(dlbg_pkg::WDEPTH)) u_wram (
    .clk(clk), .we(w_we), .waddr(w_waddr), .wdata(w_wdata),
    .re(w_re), .raddr(w_raddr), .rdata(w_rdata)
  );

  dlbg_ram #(.WIDTH(dlbg_pkg::ACC_W), .DEPTH(MAX_INPUTS)) u_aram (
    .clk(clk), .we(a_we), .waddr(a_waddr), .wdata(a_wdata),
    .re(issue), .raddr(cnt_r[IW-1:0]), .rdata(a_rdata)
  );

  // sequencer
  always_comb begin
    state_nxt     = state_r;
    rc_nxt        = rc_r;
    cnt_nxt       = cnt_r;
    vb_nxt        = vb_r;
    vc_nxt        = vc_r;
    acc_vld_nxt   = acc_vld_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          case (in_ch.func)
            dlbg_pkg::FN_NODE_STEP: begin
              if (in_ch.index < dlbg_pkg::INDEX_W'(m_eff)) state_nxt = ST_MUL1;
            end
            dlbg_pkg::FN_RD_COSTS: begin
              state_nxt = ST_RUN;
              rc_nxt    = 1'b1;
              cnt_nxt   = '0;
            end
            dlbg_pkg::FN_UPD_WEIGHT: state_nxt = ST_UPD1;
            default: ;
          endcase
        end
      end
      ST_MUL1: state_nxt = ST_MUL2;
      ST_MUL2: state_nxt = ST_BIAS;
      ST_BIAS: begin
        if (adv) begin
          out_valid_nxt = 1'b1;
          state_nxt     = ST_RUN;
          rc_nxt        = 1'b0;
          cnt_nxt       = '0;
        end
      end
      ST_RUN: begin
        if (adv) begin
          vb_nxt = issue;
          vc_nxt = vb_r;
          if (issue) cnt_nxt = cnt_r + 1'b1;
          if (vc_r) begin
            out_valid_nxt = 1'b1;
            if (!rc_r) acc_vld_nxt[i_c_r] = 1'b1;
          end
        end
        if (run_done) begin
          state_nxt = ST_IDLE;
          if (rc_r) acc_vld_nxt = '0;
        end
      end
      ST_UPD1: state_nxt = ST_UPD2;
      ST_UPD2: state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      rc_r        <= 1'b0;
      cnt_r       <= '0;
      vb_r        <= 1'b0;
      vc_r        <= 1'b0;
      acc_vld_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      rc_r        <= rc_nxt;
      cnt_r       <= cnt_nxt;
      vb_r        <= vb_nxt;
      vc_r        <= vc_nxt;
      acc_vld_r   <= acc_vld_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (in_acc) begin
      idx_r <= in_ch.index;
      val_r <= in_ch.value;
      toc_r <= in_ch.target_or_cost;
      if ((in_ch.func == dlbg_pkg::FN_WR_INPUT) && (in_ch.index < NI_LIM)) begin
        in_store[in_ch.index[IW-1:0]] <= in_ch.value;
      end
    end
    case (state_r)
      ST_MUL1: begin
        p1_r   <= 33'(val_r) * 33'(omv);
        base_r <= WAW'(idx_r * n_eff);
      end
      ST_MUL2: p2_r <= 33'(dif) * 33'(s_val);
      ST_BIAS: begin
        if (adv) begin
          bias_r  <= bias_val;
          waddr_r <= base_r;
          kind_r  <= dlbg_pkg::KIND_BIAS;
          pos_r   <= idx_r;
          cost_r  <= bias_val;
          last_r  <= 1'b0;
        end
      end
      ST_RUN: begin
        if (adv) begin
          // stage A -> B
          i_b_r    <= cnt_r[IW-1:0];
          last_b_r <= (cnt_r == n_eff - 1'b1);
          wa_b_r   <= waddr_r;
          if (issue) waddr_r <= waddr_r + 1'b1;
          // stage B -> C
          i_c_r    <= i_b_r;
          last_c_r <= last_b_r;
          wa_c_r   <= wa_b_r;
          pw_r     <= 33'(bias_r) * 33'($signed(w_rdata));
          pi_r     <= 33'(bias_r) * 33'(in_store[i_b_r]);
          acc_c_r  <= acc_vld_r[i_b_r] ? $signed(a_rdata) : 32'sd0;
          // stage C -> result register
          if (vc_r) begin
            last_r <= last_c_r;
            if (rc_r) begin
              kind_r <= dlbg_pkg::KIND_INPUT;
              pos_r  <= dlbg_pkg::INDEX_W'(i_c_r);
              cost_r <= dlbg_pkg::sat16(acc_c_r[31] ?
                          ((acc_c_r < -32'sd32768) ? -21'sd32769 : acc_c_r[20:0]) :
                          ((acc_c_r > 32'sd32767) ? 21'sd32768 : acc_c_r[20:0]));
            end else begin
              kind_r <= dlbg_pkg::KIND_WEIGHT;
              pos_r  <= dlbg_pkg::INDEX_W'(wa_c_r);
              cost_r <= dlbg_pkg::sat16(dlbg_pkg::rnd12(pi_r));
            end
          end
        end
      end
      ST_UPD1: p1_r <= 33'($signed({1'b0, lr_r})) * 33'(val_r);
      default: ;
    endcase
  end

  assign out_ch.valid    = out_valid_r;
  assign out_ch.kind     = kind_r;
  assign out_ch.position = pos_r;
  assign out_ch.cost     = cost_r;
  assign out_ch.last     = last_r;

endmodule
`default_nettype wire

// ----- rtl/dlbg_chk.sv -----
// Port-level checker for the gradient engine, bound to the top level.
`default_nettype none
module dlbg_chk (
  input wire logic                           clk,
  input wire logic                           rst_n,
  input wire logic                           in_valid,
  input wire logic                           in_ready,
  input wire logic                           out_valid,
  input wire logic                           out_ready,
  input wire logic [dlbg_pkg::KIND_W-1:0]    out_kind,
  input wire logic [dlbg_pkg::INDEX_W-1:0]   out_position,
  input wire logic [dlbg_pkg::VAL_W-1:0]     out_cost,
  input wire logic                           out_last
);

  // stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_cost) && $stable(out_position))
    else $error("result changed while stalled");

  // reset empties the result register
  a_rst: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // a bias cost always has weight costs behind it
  a_bias: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_kind == dlbg_pkg::KIND_BIAS) |-> !out_last)
    else $error("bias cost flagged last");

  // no result kind beyond input cost
  a_kind: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_kind == dlbg_pkg::KIND_BIAS) || (out_kind == dlbg_pkg::KIND_WEIGHT) ||
                  (out_kind == dlbg_pkg::KIND_INPUT))
    else $error("bad result kind");

  // the engine takes nothing while a bias cost is being shown before its weights
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_kind == dlbg_pkg::KIND_BIAS) |-> !in_ready)
    else $error("ready during node step");

endmodule

bind dense_layer_backprop_gradients dlbg_chk u_dlbg_chk (
  .clk(clk), .rst_n(rst_n),
  .in_valid(in_ch.valid), .in_ready(in_ch.ready),
  .out_valid(out_ch.valid), .out_ready(out_ch.ready),
  .out_kind(out_ch.kind), .out_position(out_ch.position),
  .out_cost(out_ch.cost), .out_last(out_ch.last)
);
`default_nettype wire

// ----- dv/dlbg_tb_if.sv -----
// Testbench-side channel interfaces are the RTL ones; this file holds the checker's result record type.
package dlbg_tb_pkg;
  import dlbg_pkg::*;
  typedef struct packed {
    kind_t              kind;
    logic [INDEX_W-1:0] position;
    logic signed [VAL_W-1:0] cost;
    logic               last;
  } grad_res_t;
endpackage

// ----- dv/dlbg_grad_checker.sv -----
// Checker: mirrors the gradient engine, predicts results and compares them.
module dlbg_grad_checker (
  input  logic clk,
  input  logic rst_n,
  dlbg_in_if  in_mon,
  dlbg_out_if out_mon,
  input  logic cfg_we,
  input  logic [dlbg_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [dlbg_pkg::LR_W-1:0] cfg_data,
  output int   fail_count,
  output int   pending,
  output int   grads_seen
);
  timeunit 1ns;
  timeprecision 1ps;
  import dlbg_pkg::*;
  import dlbg_tb_pkg::*;

  logic [5:0]  m_inputs, m_nodes;
  logic        m_last_layer;
  logic [12:0] m_rate;
  longint      w_mem [1024];
  longint      x_mem [32];
  longint      acc_mem [32];
  grad_res_t   expected_q [$];

  function automatic longint q12(longint p);
    longint q;
    q = p + 2048;
    if (q >= 0) return q / 4096;
    return -((-q + 4095) / 4096);
  endfunction

  function automatic longint clip(longint v, longint lo, longint hi);
    return v > hi ? hi : (v < lo ? lo : v);
  endfunction

  function automatic void push_grad(kind_t k, int pos, longint c, bit l);
    grad_res_t r;
    r.kind = k; r.position = pos[9:0]; r.cost = c[15:0]; r.last = l;
    expected_q = {expected_q, r};
  endfunction

  task automatic predict_item(logic [2:0] fn, logic [9:0] idx,
                              logic signed [15:0] val, logic signed [15:0] toc);
    int n, m, a;
    longint s, bias;
    n = m_inputs == 0 ? 1 : (m_inputs > 32 ? 32 : m_inputs);
    m = m_nodes == 0 ? 1 : (m_nodes > 32 ? 32 : m_nodes);
    case (fn)
      FN_WR_WEIGHT: w_mem[idx] = val;
      FN_WR_INPUT:  if (idx < 32) x_mem[idx] = val;
      FN_NODE_STEP: if (idx < m) begin
        s = clip(q12(longint'(val) * (4096 - longint'(val))), -32768, 32767);
        if (m_last_layer) bias = clip(q12((longint'(val) - toc) * s), -32768, 32767);
        else bias = clip(q12(longint'(toc) * s), -32768, 32767);
        push_grad(KIND_BIAS, idx, bias, 0);
        for (int i = 0; i < n; i++) begin
          a = (idx * n + i) % 1024;
          push_grad(KIND_WEIGHT, a, clip(q12(bias * x_mem[i]), -32768, 32767), i == n - 1);
          acc_mem[i] = clip(acc_mem[i] + q12(bias * w_mem[a]), -64'sd2147483648,
                            64'sd2147483647);
        end
      end
      FN_RD_COSTS: begin
        for (int i = 0; i < n; i++)
          push_grad(KIND_INPUT, i, clip(acc_mem[i], -32768, 32767), i == n - 1);
        foreach (acc_mem[i]) acc_mem[i] = 0;
      end
      FN_UPD_WEIGHT:
        w_mem[idx] = clip(w_mem[idx] - q12(longint'(m_rate) * val), -32768, 32767);
      default: ;
    endcase
  endtask

  assign pending = expected_q.size();

  always @(posedge clk) begin
    grad_res_t exp_r;
    if (!rst_n) begin
      m_inputs <= 6'd32; m_nodes <= 6'd32; m_last_layer <= 1'b1; m_rate <= 13'd410;
      foreach (w_mem[i]) w_mem[i] = 0;
      foreach (x_mem[i]) x_mem[i] = 0;
      foreach (acc_mem[i]) acc_mem[i] = 0;
      expected_q.delete();
      fail_count <= 0;
      grads_seen <= 0;
    end else begin
      if (cfg_we) begin
        case (reg_idx_t'(cfg_index))
          REG_NUM_INPUTS: m_inputs <= cfg_data[5:0];
          REG_NUM_NODES:  m_nodes <= cfg_data[5:0];
          REG_LAST_LAYER: m_last_layer <= cfg_data[0];
          REG_LRATE:      m_rate <= cfg_data;
          default: ;
        endcase
      end
      if (in_mon.valid && in_mon.ready)
        predict_item(in_mon.func, in_mon.index, in_mon.value, in_mon.target_or_cost);
      if (out_mon.valid && out_mon.ready) begin
        grads_seen <= grads_seen + 1;
        if (expected_q.size() == 0) begin
          if (fail_count < 10)
            $display("unexpected result kind=%0d pos=%0d cost=%0d last=%0d",
                     out_mon.kind, out_mon.position, out_mon.cost, out_mon.last);
          fail_count <= fail_count + 1;
        end else begin
          exp_r = expected_q.pop_front();
          if (exp_r.kind !== out_mon.kind || exp_r.position !== out_mon.position ||
              exp_r.cost !== out_mon.cost || exp_r.last !== out_mon.last) begin
            if (fail_count < 10)
              $display("mismatch: exp kind=%0d pos=%0d cost=%0d last=%0d, got %0d %0d %0d %0d",
                       exp_r.kind, exp_r.position, exp_r.cost, exp_r.last,
                       out_mon.kind, out_mon.position, out_mon.cost, out_mon.last);
            fail_count <= fail_count + 1;
          end
        end
      end
    end
  end
endmodule

// ----- dv/dense_layer_backprop_gradients_tb.sv -----
// Testbench top: stimulus, configuration phases and the verdict.
module dense_layer_backprop_gradients_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import dlbg_pkg::*;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [LR_W-1:0] cfg_data = '0;
  int fail_count, pending, grads_seen;
  int idle_pct = 0, stall_pct = 0;
  int quiet_cycles = 0, items_sent = 0;
  int cur_inputs = 32, cur_nodes = 32;
  int live_nodes = 1;
  bit weights_loaded [1024];
  bit inputs_loaded [32];

  localparam int WATCHDOG = 20000;

  dlbg_in_if  in_ch ();
  dlbg_out_if out_ch ();

  always #1 clk = ~clk;

  dense_layer_backprop_gradients i_dut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch.sink), .out_ch(out_ch.source),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  dlbg_grad_checker i_checker (
    .clk(clk), .rst_n(rst_n), .in_mon(in_ch), .out_mon(out_ch),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .fail_count(fail_count), .pending(pending), .grads_seen(grads_seen)
  );

  initial begin
    in_ch.valid = 1'b0;
    in_ch.func = '0;
    in_ch.index = '0;
    in_ch.value = '0;
    in_ch.target_or_cost = '0;
    out_ch.ready = 1'b0;
  end

  // Receiver: random backpressure per phase.
  always @(posedge clk)
    out_ch.ready <= ($urandom_range(99) >= stall_pct);

  // Watchdog: no transaction on either side for too long ends the run.
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) quiet_cycles <= 0;
    else if (rst_n) quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles > WATCHDOG) begin
      $display("watchdog expired, %0d results outstanding", pending);
      $display("Verification failed");
      $finish;
    end
  end

  // One transaction; random sender gap first. Valid stays up after the
  // transaction so back-to-back items need no extra edge.
  task automatic send(func_t fn, int idx, int val, int toc);
    while ($urandom_range(99) < idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.func <= fn;
    in_ch.index <= idx[9:0];
    in_ch.value <= val[15:0];
    in_ch.target_or_cost <= toc[15:0];
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    items_sent++;
    if (fn == FN_WR_WEIGHT) weights_loaded[idx % 1024] = 1'b1;
    if (fn == FN_WR_INPUT && idx < 32) inputs_loaded[idx] = 1'b1;
  endtask

  task automatic send_raw(logic [2:0] fn, int idx, int val, int toc);
    send(func_t'(fn), idx, val, toc);
  endtask

  // Quiesce, then cover the no-result tail (update weight latency).
  task automatic drain();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(reg_idx_t r, int v);
    cfg_we <= 1'b1;
    cfg_index <= r;
    cfg_data <= v[12:0];
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    if (r == REG_NUM_INPUTS) cur_inputs = v[5:0] == 0 ? 1 : (v[5:0] > 32 ? 32 : v[5:0]);
    if (r == REG_NUM_NODES) cur_nodes = v[5:0] == 0 ? 1 : (v[5:0] > 32 ? 32 : v[5:0]);
  endtask

  // Load every input and every weight of the live nodes not yet written.
  task automatic load_stores(int nodes);
    live_nodes = (nodes > cur_nodes) ? cur_nodes : nodes;
    for (int i = 0; i < cur_inputs; i++)
      if (!inputs_loaded[i]) send(FN_WR_INPUT, i, $urandom_range(65535), 0);
    for (int a = 0; a < live_nodes * cur_inputs; a++)
      if (!weights_loaded[a]) send(FN_WR_WEIGHT, a, $urandom_range(65535), 0);
  endtask

  function automatic int rnd_val();
    case ($urandom_range(5))
      0: return 32767;
      1: return -32768;
      2: return $urandom_range(4096);
      default: return $urandom_range(65535);
    endcase
  endfunction

  // Mostly node steps with occasional reads, updates and noise.
  task automatic random_items(int count);
    int sel;
    for (int k = 0; k < count; k++) begin
      sel = $urandom_range(99);
      if (sel < 50)
        send(FN_NODE_STEP, $urandom_range(live_nodes - 1), rnd_val(), rnd_val());
      else if (sel < 62) send(FN_RD_COSTS, $urandom_range(1023), rnd_val(), rnd_val());
      else if (sel < 74)
        send(FN_UPD_WEIGHT, $urandom_range(live_nodes * cur_inputs - 1), rnd_val(), 0);
      else if (sel < 82) send(FN_WR_INPUT, $urandom_range(1023), rnd_val(), 0);
      else if (sel < 88)
        send(FN_WR_WEIGHT, $urandom_range(1023), rnd_val(), 0);
      else if (sel < 94)
        send(FN_NODE_STEP, cur_nodes + $urandom_range(1023 - cur_nodes), rnd_val(), 0);
      else send_raw(3'($urandom_range(5, 7)), $urandom_range(1023), rnd_val(), rnd_val());
    end
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: default config (32x32, last layer), store load, extremes.
    load_stores(1);
    send(FN_NODE_STEP, 0, 32767, -32768);
    send(FN_NODE_STEP, 0, -32768, 32767);
    send(FN_NODE_STEP, 0, 2048, 0);
    send(FN_NODE_STEP, 32, 100, 100);          // out-of-range node, ignored
    send(FN_WR_INPUT, 40, 1234, 0);            // out-of-range input, ignored
    send(FN_UPD_WEIGHT, 31, -32768, 0);
    send(FN_UPD_WEIGHT, 0, 32767, 0);
    send_raw(3'd7, 1023, 32767, -1);           // unused func code
    send(FN_RD_COSTS, 0, 0, 0);
    drain();
    // Pressure: a pause until everything has drained, done above.

    // Upstream-cost mode, rate 1.0, tiny layer; zero counts clamp to one.
    write_reg(REG_LAST_LAYER, 0);
    write_reg(REG_LRATE, 4096);
    write_reg(REG_NUM_INPUTS, 0);
    write_reg(REG_NUM_NODES, 0);
    load_stores(1);
    send(FN_NODE_STEP, 0, -32768, -32768);
    send(FN_NODE_STEP, 0, 32767, 32767);
    send(FN_RD_COSTS, 1023, 0, 0);
    random_items(10);
    drain();

    // Random phases across idling profiles and layouts.
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 73; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 73; end
        default: begin idle_pct = 9; stall_pct = 9; end
      endcase
      write_reg(REG_NUM_INPUTS, ph == 3 ? 63 : $urandom_range(1, 12));
      write_reg(REG_NUM_NODES, ph == 0 ? 63 : $urandom_range(1, 32));
      write_reg(REG_LAST_LAYER, ph[0]);
      write_reg(REG_LRATE, ph == 1 ? 0 : $urandom_range(8191));
      load_stores(ph == 3 ? 1 : 2);
      random_items(16);
      drain();
    end

    $display("Ran %0d input transactions, %0d result transactions checked,", items_sent,
             grads_seen);
    $display("over both cost modes, clamped and full layouts and four idling profiles.");
    if (fail_count == 0) $display("Verification passed");
    else $display("Verification failed");
    $finish;
  end
endmodule

// ----- sim.f -----
rtl/dlbg_pkg.sv
rtl/dlbg_if.sv
rtl/dlbg_ram.sv
rtl/dense_layer_backprop_gradients.sv
rtl/dlbg_chk.sv
dv/dlbg_tb_if.sv
dv/dlbg_grad_checker.sv
dv/dense_layer_backprop_gradients_tb.sv
